// ===== design/three_pad_touch_gesture_qualifier_core_assert.svh =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - assertion macros
// Shared assertion wrappers for the checker of the qualifier core.
// ----------------------------------------------------------------------------
`ifndef THREE_PAD_TOUCH_GESTURE_QUALIFIER_CORE_ASSERT_SVH
`define THREE_PAD_TOUCH_GESTURE_QUALIFIER_CORE_ASSERT_SVH

// Property checked at every rising edge while reset is released.
`define TPGQ_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define TPGQ_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tpgq_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - package
// Widths, codes and the structs passed between the qualifier modules.
// ----------------------------------------------------------------------------
package tpgq_pkg;

    localparam int NUM_PADS = 3;
    localparam int PAD_W    = 2;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int THR_W    = 16;
    localparam int PAT_W    = NUM_PADS;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [TIME_W-1:0]  INTERVAL_RESET    = 32'd100;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET   = 16'd3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    typedef enum logic {
        CMD_PAD_EVENT = 1'b0,
        CMD_CHECK     = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_HOLD_INTERVAL  = 1'b0,
        REG_HOLD_THRESHOLD = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd               command;
        logic [PAD_W-1:0]   pad;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    // Per-pad step control: update strobe, kind of step, event address match.
    typedef struct packed {
        logic               upd;
        logic               is_check;
        logic               hit;
        logic [TIME_W-1:0]  now_ms;
    } t_pad_ctl;

    typedef struct packed {
        logic upd;
        logic is_check;
    } t_pat_ctl;

    typedef struct packed {
        logic              touch_detected;
        logic [PAT_W-1:0]  active_pattern;
    } t_result;

endpackage

// ===== design/tpgq_pad_unit.sv =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - pad unit
// Holds one pad's last event time and its saturating hold counter.
// ----------------------------------------------------------------------------
module tpgq_pad_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tpgq_pkg::t_pad_ctl         i_ctl,
    input  logic [tpgq_pkg::TIME_W-1:0] i_interval,
    output logic [tpgq_pkg::COUNT_W-1:0] o_count_next
);
    import tpgq_pkg::*;

    logic [TIME_W-1:0]  r_last;
    logic [TIME_W-1:0]  n_last;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [TIME_W-1:0]  elapsed;
    logic               held;

    // Elapsed time wraps modulo 2^32, which the plain subtraction gives.
    assign elapsed = i_ctl.now_ms - r_last;
    assign held    = (elapsed < i_interval);

    always_comb begin
        n_last  = r_last;
        n_count = r_count;
        if (i_ctl.upd) begin
            if (i_ctl.is_check) begin
                if (!held) begin
                    n_count = '0;
                end else if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end else if (i_ctl.hit) begin
                n_last = i_ctl.now_ms;
            end
        end
    end

    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_count <= '0;
        end else begin
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/tpgq_pattern_unit.sv =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - pattern unit
// Forms the pad pattern from the hold counters and latches new touches.
// ----------------------------------------------------------------------------
module tpgq_pattern_unit (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  tpgq_pkg::t_pat_ctl                            i_ctl,
    input  logic [tpgq_pkg::NUM_PADS-1:0][tpgq_pkg::COUNT_W-1:0] i_counts,
    input  logic [tpgq_pkg::THR_W-1:0]                    i_threshold,
    output tpgq_pkg::t_result                             o_next
);
    import tpgq_pkg::*;

    logic [PAT_W-1:0] r_prev;
    logic [PAT_W-1:0] n_prev;
    logic [PAT_W-1:0] r_latched;
    logic [PAT_W-1:0] n_latched;
    logic             r_detected;
    logic             n_detected;
    logic [PAT_W-1:0] nonzero;
    logic [PAT_W-1:0] over;
    logic [PAT_W-1:0] pattern;

    always_comb begin
        for (int p = 0; p < NUM_PADS; p++) begin
            nonzero[p] = (i_counts[p] != '0);
            over[p]    = (i_counts[p] > i_threshold);
        end
    end

    // Only pads with a live counter show, and only once some pad is over.
    assign pattern = (|over) ? nonzero : '0;

    always_comb begin
        n_prev     = r_prev;
        n_latched  = r_latched;
        n_detected = r_detected;
        if (i_ctl.upd && i_ctl.is_check) begin
            if (pattern == '0) begin
                n_prev     = '0;
                n_latched  = '0;
                n_detected = 1'b0;
            end else if (r_prev == '0) begin
                n_prev     = pattern;
                n_latched  = pattern;
                n_detected = 1'b1;
            end else begin
                n_detected = 1'b0;
            end
        end
    end

    assign o_next.touch_detected = n_detected;
    assign o_next.active_pattern = n_latched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_latched  <= '0;
            r_detected <= 1'b0;
        end else begin
            r_prev     <= n_prev;
            r_latched  <= n_latched;
            r_detected <= n_detected;
        end
    end

endmodule

// ===== design/three_pad_touch_gesture_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - core
// Stream-in pad events and check ticks, stream-out detected flag and pattern.
// ----------------------------------------------------------------------------
// The core takes one beat per clock cycle while the master side takes its
// results, and returns exactly one result beat per input beat, in order.
// A beat accepted into the input register is processed by the pad units and
// the pattern unit, and its result is captured in the result register, from
// which it is valid on the master side. The sustained rate is one beat per
// cycle while results are taken, and is set by the state update path: a
// 32-bit wrapped subtract and compare per pad, a 16-bit saturating increment,
// the threshold compare and the latch decision. The input register keeps
// accepting while a result waits on the master side as long as that result
// is taken in the same cycle; a stalled master side backs up into the input
// register and then drops s_axis_tready. Configuration registers (hold
// interval at address 0x0, hold threshold at 0x4) should only be written
// while no beat is in flight. There are no memories and no clearing pass.
// ----------------------------------------------------------------------------
module three_pad_touch_gesture_qualifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] pad, [33:2] now_ms, [39:34] zero
    input  logic [tpgq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                               s_axis_tuser,
    // Master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] touch_detected, [3:1] active_pattern, [7:4] zero
    output logic [tpgq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tpgq_pkg::ADDR_W-1:0]        paddr,
    input  logic [tpgq_pkg::DATA_W-1:0]        pwdata,
    output logic [tpgq_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import tpgq_pkg::*;

    // ---------------- Configuration registers ----------------
    logic [TIME_W-1:0] r_interval;
    logic [THR_W-1:0]  r_threshold;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // Registers sit at word addresses; the byte offset bits are not decoded.
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HOLD_INTERVAL:  r_interval  <= pwdata[TIME_W-1:0];
                REG_HOLD_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HOLD_INTERVAL:  prdata = DATA_W'(r_interval);
            REG_HOLD_THRESHOLD: prdata = DATA_W'(r_threshold);
            default:            prdata = '0;
        endcase
    end

    // ---------------- Pipeline control ----------------
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    logic    advance;
    logic    in_take;

    // The input register moves into the result register whenever the result
    // register is empty or its beat is being taken this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command <= t_cmd'(s_axis_tuser);
            r_item.pad     <= s_axis_tdata[PAD_W-1:0];
            r_item.now_ms  <= s_axis_tdata[PAD_W+TIME_W-1:PAD_W];
        end
    end

    // ---------------- Processing ----------------
    logic [NUM_PADS-1:0][COUNT_W-1:0] counts_next;
    t_pat_ctl                         pat_ctl;
    t_result                          result_next;
    logic                             is_check;

    assign is_check = (r_item.command == CMD_CHECK);

    // A pad event to slot three matches no pad unit and is dropped.
    for (genvar g = 0; g < NUM_PADS; g++) begin : g_pad
        t_pad_ctl pad_ctl;

        assign pad_ctl.upd      = advance;
        assign pad_ctl.is_check = is_check;
        assign pad_ctl.hit      = (r_item.pad == PAD_W'(g));
        assign pad_ctl.now_ms   = r_item.now_ms;

        tpgq_pad_unit u_pad (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (pad_ctl),
            .i_interval   (r_interval),
            .o_count_next (counts_next[g])
        );
    end

    assign pat_ctl.upd      = advance;
    assign pat_ctl.is_check = is_check;

    tpgq_pattern_unit u_pattern (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pat_ctl),
        .i_counts    (counts_next),
        .i_threshold (r_threshold),
        .o_next      (result_next)
    );

    // ---------------- Result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - PAT_W - 1)'(0),
                            r_result.active_pattern,
                            r_result.touch_detected};

endmodule

// ===== design/tpgq_checker.sv =====
// ----------------------------------------------------------------------------
// Three-pad touch gesture qualifier - port checker
// Watches the core's ports over time and is bound to the core.
// ----------------------------------------------------------------------------
`include "three_pad_touch_gesture_qualifier_core_assert.svh"

module tpgq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tpgq_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import tpgq_pkg::*;

    // A stalled result beat holds its data.
    `TPGQ_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // A new touch always comes with a nonzero latched pattern.
    `TPGQ_ASSERT_RUN(a_detect_pattern, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[PAT_W:1] != '0, "touch reported with empty pattern")

    // With the result side empty the core must take a new beat.
    `TPGQ_ASSERT_RUN(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty result register")

    // Reset empties the result side.
    `TPGQ_ASSERT_ALL(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind three_pad_touch_gesture_qualifier_core tpgq_checker u_tpgq_checker (.*);
